/* design/fss_pkg.sv */
`default_nettype none

package fss_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int BASELINE_W = 12;
    localparam int RANGE_W    = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;

    localparam int DELTA_W    = 12;
    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 16;
    localparam int NUM_W      = 18;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int FORCE_W    = 16;
    localparam int BEND_W     = 11;
    localparam int BRIGHT_W   = 7;
    localparam int OUT_BITS   = FORCE_W + BEND_W + BRIGHT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int ROOT_SHIFT = 19;
    localparam int Q15_SHIFT  = 15;
    localparam int DIV5_SHIFT = 18;
    localparam int BRIGHT_SHIFT = 7;

    localparam logic [BASELINE_W-1:0] BASELINE_RST = 12'd200;
    localparam logic [RANGE_W-1:0]    RANGE_RST    = 11'd200;
    localparam logic [DELTA_W-1:0]    FULL_DELTA   = 12'd2048;
    localparam logic [MUL_B_W-1:0]    DIV5_RECIP   = 16'd52429;

    localparam logic [CFG_ADDR_W-1:0] CFG_BASELINE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BEND_RANGE = 1'b1;

endpackage

`default_nettype wire

/* design/fss_isqrt.sv */
`default_nettype none

module fss_isqrt
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [fss_pkg::RADICAND_W-1:0]    radicand,
    output logic                                   busy,
    output logic                                   done,
    output logic [fss_pkg::ROOT_W-1:0]             root
);

    localparam int W = fss_pkg::RADICAND_W;
    localparam int STEPS = W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
    localparam logic [W-1:0] TOP_BIT = W'(1) << (W - 2);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     root_reg, root_next;
    logic [W-1:0]     bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W-1:0]     trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = TOP_BIT;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg[fss_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

/* design/force_sensor_sqrt_smoother.sv */
// A new sample is taken only in idle. Each item then passes through 16 square-root steps
// in the square-root unit, the sum, two passes through one shared multiplier, the force
// update, the output load and idle.
// A finished result waits in the output register while the next item is taken; if it is
// still not taken when the next result is ready, hold until the output transfer.
// Reset (rst_n, asynchronous, active low): baseline 200, bend_range 200, force 0, no result.
`default_nettype none

module force_sensor_sqrt_smoother
#(
    parameter int SAMPLE_BITS = fss_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // sample
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // force_res, bend_cents, brightness
    output logic [fss_pkg::OUT_TDATA_W-1:0]            m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fss_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int CMP_W = (SAMPLE_BITS > fss_pkg::BASELINE_W) ?
                           SAMPLE_BITS : fss_pkg::BASELINE_W;
    localparam int PAD_W = fss_pkg::OUT_TDATA_W - fss_pkg::OUT_BITS;
    localparam int BR_W  = fss_pkg::FORCE_W + fss_pkg::BRIGHT_SHIFT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROOT  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FORCE = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [fss_pkg::BASELINE_W-1:0]      baseline_reg;
    logic [fss_pkg::RANGE_W-1:0]         bend_range_reg;
    logic [fss_pkg::FORCE_W-1:0]         smoothed_reg;
    logic [fss_pkg::NUM_W-1:0]           num_reg;
    logic [fss_pkg::PROD_W-1:0]          prod_reg;
    logic [fss_pkg::FORCE_W-1:0]         force_reg;
    logic [fss_pkg::OUT_TDATA_W-1:0]     m_tdata_reg;
    logic                                m_tvalid_reg;

    logic                                in_xfer;
    logic                                out_load;
    logic [CMP_W-1:0]                    sample_ext;
    logic [CMP_W-1:0]                    baseline_ext;
    logic [CMP_W-1:0]                    diff;
    logic [fss_pkg::DELTA_W-1:0]         delta;
    logic [fss_pkg::RADICAND_W-1:0]      radicand;
    logic                                root_busy;
    logic                                root_done;
    logic [fss_pkg::ROOT_W-1:0]          root;
    logic [fss_pkg::MUL_A_W-1:0]         mul_a;
    logic [fss_pkg::MUL_B_W-1:0]         mul_b;
    logic [BR_W-1:0]                     bright_prod;
    logic [fss_pkg::BEND_W-1:0]          bend_val;
    logic [fss_pkg::BRIGHT_W-1:0]        bright_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // clamp sample - baseline to 0..FULL_DELTA
    assign sample_ext   = CMP_W'(s_tdata[SAMPLE_BITS-1:0]);
    assign baseline_ext = CMP_W'(baseline_reg);
    assign diff         = sample_ext - baseline_ext;

    always_comb
    begin
        priority if (sample_ext <= baseline_ext)
            delta = '0;
        else if (diff > CMP_W'(fss_pkg::FULL_DELTA))
            delta = fss_pkg::FULL_DELTA;
        else
            delta = diff[fss_pkg::DELTA_W-1:0];
    end

    assign radicand = fss_pkg::RADICAND_W'(delta) << fss_pkg::ROOT_SHIFT;

    fss_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .radicand (radicand),
        .busy     (root_busy),
        .done     (root_done),
        .root     (root)
    );

    always_comb
    begin
        mul_a = fss_pkg::MUL_A_W'(force_reg);
        mul_b = fss_pkg::MUL_B_W'(bend_range_reg);
        if (state_reg == ST_DIV)
        begin
            mul_a = num_reg;
            mul_b = fss_pkg::DIV5_RECIP;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                    state_next = ST_ROOT;
            ST_ROOT:
                if (root_done && !root_busy)
                    state_next = ST_DIV;
            ST_DIV:
                state_next = ST_FORCE;
            ST_FORCE:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign bright_prod = {force_reg, {fss_pkg::BRIGHT_SHIFT{1'b0}}} - BR_W'(force_reg);
    assign bright_val  = bright_prod[fss_pkg::Q15_SHIFT +: fss_pkg::BRIGHT_W];
    assign bend_val    = prod_reg[fss_pkg::Q15_SHIFT +: fss_pkg::BEND_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            baseline_reg   <= fss_pkg::BASELINE_RST;
            bend_range_reg <= fss_pkg::RANGE_RST;
            smoothed_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_addr)
                    fss_pkg::CFG_BASELINE:
                        baseline_reg <= cfg_data[fss_pkg::BASELINE_W-1:0];
                    fss_pkg::CFG_BEND_RANGE:
                        bend_range_reg <= cfg_data[fss_pkg::RANGE_W-1:0];
                    default:
                        baseline_reg <= baseline_reg;
                endcase
            end
            if (state_reg == ST_FORCE)
                smoothed_reg <= prod_reg[fss_pkg::DIV5_SHIFT +: fss_pkg::FORCE_W];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ROOT) && root_done)
            num_reg <= {smoothed_reg, 2'b00} + fss_pkg::NUM_W'(root);
        if ((state_reg == ST_DIV) || (state_reg == ST_SCALE))
            prod_reg <= mul_a * mul_b;
        if (state_reg == ST_FORCE)
            force_reg <= prod_reg[fss_pkg::DIV5_SHIFT +: fss_pkg::FORCE_W];
        if (out_load)
            m_tdata_reg <= {{PAD_W{1'b0}}, bright_val, bend_val, force_reg};
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ONE_Q15      = 32768;
    localparam int unsigned BRIGHT_MAX   = 127;
    localparam int unsigned SMP_MAX      = 4095;
    localparam int unsigned RANGE_MAX    = 2047;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [fss_pkg::FORCE_W-1:0]  force_q15;
        logic [fss_pkg::BEND_W-1:0]   bend;
        logic [fss_pkg::BRIGHT_W-1:0] bright;
    } smoother_out_t;

    logic                            clk;
    logic                            rst_n;
    logic [15:0]                     s_tdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fss_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fss_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic [fss_pkg::BASELINE_W-1:0]  baseline_reg;
    logic [fss_pkg::RANGE_W-1:0]     bend_range_reg;
    int unsigned                     smooth_force;
    smoother_out_t                   expected_results[$];
    int                              fail_count;
    int                              cycle_count;
    logic                            steady_flow;
    int                              stall_left;

    force_sensor_sqrt_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),      // [11:0] sample
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),      // [15:0] force_res, [26:16] bend_cents, [33:27] brightness
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return int'(root);
    endfunction

    function automatic smoother_out_t advance_smoother(input logic [11:0] smp);
        int unsigned   delta;
        int unsigned   target;
        int unsigned   level;
        smoother_out_t r;
        delta = (smp > baseline_reg) ? smp - baseline_reg : 0;
        if (delta > fss_pkg::FULL_DELTA)
            delta = fss_pkg::FULL_DELTA;
        target = floor_sqrt(64'(delta) << fss_pkg::ROOT_SHIFT);
        if (target > ONE_Q15)
            target = ONE_Q15;
        level = (4 * smooth_force + target) / 5;
        if (level > ONE_Q15)
            level = ONE_Q15;
        smooth_force = level;
        r.force_q15 = level[fss_pkg::FORCE_W-1:0];
        r.bend      = fss_pkg::BEND_W'((level * bend_range_reg) >> fss_pkg::Q15_SHIFT);
        r.bright    = fss_pkg::BRIGHT_W'((level * BRIGHT_MAX) >> fss_pkg::Q15_SHIFT);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        smoother_out_t want;
        smoother_out_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.force_q15 = m_tdata[fss_pkg::FORCE_W-1:0];
            got.bend      = m_tdata[fss_pkg::FORCE_W +: fss_pkg::BEND_W];
            got.bright    = m_tdata[fss_pkg::FORCE_W+fss_pkg::BEND_W +: fss_pkg::BRIGHT_W];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: force_res %0d", got.force_q15);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.force_q15 !== want.force_q15)
                begin
                    $error("force_res: expected %0d, actual %0d", want.force_q15, got.force_q15);
                    fail_count++;
                end
                if (got.bend !== want.bend)
                begin
                    $error("bend_cents: expected %0d, actual %0d", want.bend, got.bend);
                    fail_count++;
                end
                if (got.bright !== want.bright)
                begin
                    $error("brightness: expected %0d, actual %0d", want.bright, got.bright);
                    fail_count++;
                end
            end
        end
    end

    // Call at a falling edge; returns at a falling edge with tvalid still high.
    task automatic send_sample(input logic [11:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {4'b0, smp};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(advance_smoother(smp));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned base, input int unsigned bend_rng);
        drain();
        cfg_valid <= 1'b1;
        cfg_addr  <= fss_pkg::CFG_BASELINE;
        cfg_data  <= fss_pkg::CFG_DATA_W'(base);
        do
            @(posedge clk);
        while (!cfg_ready);
        baseline_reg = fss_pkg::BASELINE_W'(base);
        @(negedge clk);
        cfg_addr <= fss_pkg::CFG_BEND_RANGE;
        cfg_data <= fss_pkg::CFG_DATA_W'(bend_rng);
        do
            @(posedge clk);
        while (!cfg_ready);
        bend_range_reg = fss_pkg::RANGE_W'(bend_rng);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_registers();
        send_sample(12'd0);
        send_sample(12'd199);
        send_sample(12'd200);
        send_sample(12'd201);
        repeat (6) send_sample(12'd4095);
        drain();
    endtask

    task automatic test_clamp_edges();
        configure(0, RANGE_MAX);
        send_sample(12'd2048);
        send_sample(12'd4095);
        send_sample(12'hAAA);
        send_sample(12'h555);
        configure(SMP_MAX, 1200);
        send_sample(12'd4095);
        send_sample(12'd0);
        configure(0, 0);
        send_sample(12'd4095);
        drain();
    endtask

    function automatic int unsigned pick_baseline();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return SMP_MAX;
            2:       return fss_pkg::BASELINE_RST;
            3:       return $urandom_range(0, SMP_MAX);
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    function automatic int unsigned pick_bend_range();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1200;
            2:       return RANGE_MAX;
            3:       return $urandom_range(0, RANGE_MAX);
            default: return $urandom_range(0, 1200);
        endcase
    endfunction

    function automatic logic [11:0] next_sample(input logic [11:0] prev);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 12'($urandom_range(0, SMP_MAX));
        if (r < 75)
        begin
            v = int'(baseline_reg) + $urandom_range(0, 16) - 8;
            if (r >= 60)
                v += fss_pkg::FULL_DELTA;
            if (v < 0)
                v = 0;
            if (v > SMP_MAX)
                v = SMP_MAX;
            return 12'(v);
        end
        return prev;
    endfunction

    task automatic test_random_traffic();
        int          sent;
        int          seg;
        logic [11:0] smp;
        sent = 0;
        smp  = 12'd0;
        configure(fss_pkg::BASELINE_RST, fss_pkg::RANGE_RST);
        while (sent < RANDOM_ITEMS)
        begin
            seg = $urandom_range(40, 160);
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat (seg)
            begin
                smp = next_sample(smp);
                send_sample(smp);
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       configure(pick_baseline(), pick_bend_range());
                1:       drain();
                default: ;
            endcase
        end
        steady_flow = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tvalid       = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_addr       = fss_pkg::CFG_BASELINE;
        cfg_data       = '0;
        steady_flow    = 1'b0;
        stall_left     = 0;
        fail_count     = 0;
        cycle_count    = 0;
        baseline_reg   = fss_pkg::BASELINE_RST;
        bend_range_reg = fss_pkg::RANGE_RST;
        smooth_force   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_registers();
        test_clamp_edges();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/fss_pkg.sv
design/fss_isqrt.sv
design/force_sensor_sqrt_smoother.sv
sim/testbench.sv
